### src/drfd_pkg.sv
// ----------------------------------------------------------------------------
// Remote frame decoder package
// Shared types and constants for the remote-control frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package drfd_pkg;

    localparam int FRAME_BYTES = 18;
    localparam int COUNT_W     = 5;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CHAN_W      = 11;
    localparam int DEADBAND_W  = 10;
    localparam int WORD_W      = 16;
    localparam int SW_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int M_TDATA_W   = 128;

    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 5'd31;
    localparam logic [COUNT_W-1:0]    COUNT_FRAME    = 5'(FRAME_BYTES);
    localparam logic [CHAN_W-1:0]     CHAN_CENTRE    = 11'h400;
    localparam logic [WORD_W-1:0]     WHEEL_OFFSET   = 16'd1024;
    localparam logic [CHAN_W-1:0]     LIMIT_RESET    = 11'd660;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 10'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_LIMIT = 1'b0,
        REG_DEADBAND      = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_IDLE = 1'b1
    } action_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic              status;
        logic [CHAN_W-1:0] stick_one;
        logic [CHAN_W-1:0] stick_two;
        logic [CHAN_W-1:0] stick_three;
        logic [CHAN_W-1:0] stick_four;
        logic [SW_W-1:0]   switch_left;
        logic [SW_W-1:0]   switch_right;
        logic [WORD_W-1:0] mouse_dx;
        logic [WORD_W-1:0] mouse_dy;
        logic [WORD_W-1:0] mouse_buttons;
        logic [WORD_W-1:0] key_bitmap;
        logic [WORD_W-1:0] wheel_value;
    } result_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } buf_status_t;

endpackage

`default_nettype wire

### src/drfd_frame_capture.sv
// ----------------------------------------------------------------------------
// Frame capture
// Stores received bytes and counts them; flags a complete frame on idle.
// ----------------------------------------------------------------------------
`default_nettype none

module drfd_frame_capture (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            beat_accept,
    input  wire logic            beat_idle,
    input  wire logic [7:0]      beat_byte,
    output drfd_pkg::frame_t     frame,
    output logic                 frame_done
);

    drfd_pkg::frame_t                  store_reg;
    logic [drfd_pkg::COUNT_W-1:0]      count_reg;
    logic [drfd_pkg::COUNT_W-1:0]      count_next;
    logic                              done_reg;
    logic                              done_next;
    logic                              store_en;

    always_comb begin
        count_next = count_reg;
        done_next  = 1'b0;
        store_en   = 1'b0;
        if (beat_accept) begin
            if (beat_idle) begin
                done_next  = (count_reg == drfd_pkg::COUNT_FRAME);
                count_next = '0;
            end else begin
                store_en = (count_reg < drfd_pkg::COUNT_FRAME);
                if (count_reg < drfd_pkg::COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            store_reg[count_reg[drfd_pkg::IDX_W-1:0]] <= beat_byte;
        end
    end

    assign frame      = store_reg;
    assign frame_done = done_reg;

endmodule

`default_nettype wire

### src/drfd_frame_decode.sv
// ----------------------------------------------------------------------------
// Frame decode
// Unpacks a stored frame into stick, switch, mouse, key and wheel fields.
// ----------------------------------------------------------------------------
`default_nettype none

module drfd_frame_decode (
    input  wire drfd_pkg::frame_t              frame,
    input  wire logic [drfd_pkg::CHAN_W-1:0]     channel_limit,
    input  wire logic [drfd_pkg::DEADBAND_W-1:0] deadband,
    output drfd_pkg::result_t                  result
);

    logic [3:0][drfd_pkg::CHAN_W-1:0] raw;
    logic [3:0][drfd_pkg::CHAN_W-1:0] centred;
    logic [3:0][drfd_pkg::CHAN_W-1:0] mag;
    logic [3:0][drfd_pkg::CHAN_W-1:0] chan;
    logic [3:0]                       over;
    logic                             bad;

    always_comb begin
        raw[0] = {frame[1][2:0], frame[0]};
        raw[1] = {frame[2][5:0], frame[1][7:3]};
        raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
        raw[3] = {frame[5][3:0], frame[4][7:1]};
        for (int k = 0; k < 4; k++) begin
            // Subtracting the centre value only flips the top bit.
            centred[k] = raw[k] ^ drfd_pkg::CHAN_CENTRE;
            mag[k]     = centred[k][drfd_pkg::CHAN_W-1] ? (~centred[k] + 1'b1) : centred[k];
            if (mag[k] <= {1'b0, deadband}) begin
                chan[k] = '0;
                over[k] = 1'b0;
            end else begin
                chan[k] = centred[k];
                over[k] = (mag[k] > channel_limit);
            end
        end
        bad = |over;

        result = '0;
        if (bad) begin
            result.status = 1'b1;
        end else begin
            result.stick_one     = chan[0];
            result.stick_two     = chan[1];
            result.stick_three   = chan[2];
            result.stick_four    = chan[3];
            result.switch_left   = frame[5][7:6];
            result.switch_right  = frame[5][5:4];
            result.mouse_dx      = {frame[7], frame[6]};
            result.mouse_dy      = {frame[9], frame[8]};
            result.mouse_buttons = {frame[13], frame[12]};
            result.key_bitmap    = {frame[15], frame[14]};
            result.wheel_value   = {frame[17], frame[16]} - drfd_pkg::WHEEL_OFFSET;
        end
    end

endmodule

`default_nettype wire

### src/drfd_out_buffer.sv
// ----------------------------------------------------------------------------
// Output buffer
// Result register with a skid stage so that input beats keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module drfd_out_buffer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire drfd_pkg::result_t push_data,
    input  wire logic              pop_ready,
    output drfd_pkg::result_t      out_data,
    output drfd_pkg::buf_status_t  status
);

    drfd_pkg::result_t out_reg;
    drfd_pkg::result_t skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              pop;

    assign pop = out_valid_reg && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
                if (push) begin
                    skid_reg <= push_data;
                end
            end else if (push) begin
                out_reg <= push_data;
            end
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

    assign out_data          = out_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

`default_nettype wire

### src/dbus_remote_frame_decoder.sv
// ----------------------------------------------------------------------------
// Remote-control frame decoder
// Collects received bytes; a line idle after exactly 18 bytes decodes a frame.
// An accepted idle beat sets a done register, which pushes the decoded result.
// Throughput: one input beat per cycle while s_tready is high; the frame
// store, the decode logic and the result register form one registered pass.
// Reset: synchronous active-low aresetn clears the byte count and the output
// buffer and loads channel_limit with 660 and deadband with 5.
// ----------------------------------------------------------------------------
`default_nettype none

module dbus_remote_frame_decoder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // data_byte
    input  wire logic                               s_tuser,  // action
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // stick_one, stick_two, stick_three, stick_four, switch_left,
    // switch_right, mouse_dx, mouse_dy, mouse_buttons, key_bitmap, wheel_value
    output logic [drfd_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tuser,  // status
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [drfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [drfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [drfd_pkg::CHAN_W-1:0]     channel_limit_reg;
    logic [drfd_pkg::DEADBAND_W-1:0] deadband_reg;
    logic                            s_accept;
    logic                            frame_done;
    drfd_pkg::frame_t                frame;
    drfd_pkg::result_t               decoded;
    drfd_pkg::result_t               out_data;
    drfd_pkg::buf_status_t           buf_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_limit_reg <= drfd_pkg::LIMIT_RESET;
            deadband_reg      <= drfd_pkg::DEADBAND_RESET;
        end else if (cfg_valid) begin
            case (drfd_pkg::cfg_reg_t'(cfg_index))
                drfd_pkg::REG_CHANNEL_LIMIT: channel_limit_reg <= cfg_data;
                drfd_pkg::REG_DEADBAND: deadband_reg <= cfg_data[drfd_pkg::DEADBAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Room is needed for the result of a frame still in the decode stage.
    assign s_tready = !(buf_status.skid_valid || (buf_status.out_valid && frame_done));
    assign s_accept = s_tvalid && s_tready;

    drfd_frame_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (s_accept),
        .beat_idle   (s_tuser == drfd_pkg::ACT_IDLE),
        .beat_byte   (s_tdata),
        .frame       (frame),
        .frame_done  (frame_done)
    );

    drfd_frame_decode u_decode (
        .frame         (frame),
        .channel_limit (channel_limit_reg),
        .deadband      (deadband_reg),
        .result        (decoded)
    );

    drfd_out_buffer u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (frame_done),
        .push_data (decoded),
        .pop_ready (m_tready),
        .out_data  (out_data),
        .status    (buf_status)
    );

    assign m_tvalid = buf_status.out_valid;
    assign m_tuser  = out_data.status;
    assign m_tdata  = {out_data.wheel_value, out_data.key_bitmap, out_data.mouse_buttons,
                       out_data.mouse_dy, out_data.mouse_dx, out_data.switch_right,
                       out_data.switch_left, out_data.stick_four, out_data.stick_three,
                       out_data.stick_two, out_data.stick_one};

    a_done_after_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |-> $past(s_accept && (s_tuser == drfd_pkg::ACT_IDLE)))
        else $error("frame decode started without an accepted idle beat");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |-> !buf_status.skid_valid)
        else $error("decoded frame arrived with the output buffer full");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("out-of-range result carries non-zero fields");

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_status.skid_valid |-> buf_status.out_valid)
        else $error("skid stage holds a beat while the output register is empty");

endmodule

`default_nettype wire
